// File: design/ofem_pkg.sv
// ----------------------------------------------------------------------------
// ofem_pkg
// Shared types, sizes and helpers for the oriented facet edge map.
// ----------------------------------------------------------------------------
`default_nettype none

package ofem_pkg;

  // map geometry
  localparam int MAX_NODES = 16;
  localparam int NODE_W    = 4;
  localparam int DEPTH     = MAX_NODES * MAX_NODES;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int ENTRY_W   = 5;

  // empty entry reads as -1
  localparam logic [ENTRY_W-1:0] EMPTY_CODE = '1;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // control from the sequencer to the edge store
  typedef struct packed {
    logic   clr;
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
  } store_req_t;

  // flat index of directed edge (from, to)
  function automatic addr_t edge_addr(input node_t from, input node_t to);
    edge_addr = ADDR_W'(int'(from) * MAX_NODES + int'(to));
  endfunction

  // corner is a legal node number
  function automatic logic node_ok(input node_t n);
    node_ok = (int'(n) < MAX_NODES);
  endfunction

endpackage

`default_nettype wire

// File: design/ofem_edge_store.sv
// ----------------------------------------------------------------------------
// ofem_edge_store
// Edge map memory with one write and one registered read port; per-entry
// valid flops, all cleared together, give the empty state after reset or clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ofem_edge_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ofem_pkg::store_req_t req,
  output logic [ofem_pkg::ENTRY_W-1:0] rd_data
);

  logic [ofem_pkg::ENTRY_W-1:0] mem [ofem_pkg::DEPTH];
  logic [ofem_pkg::DEPTH-1:0]   vld;
  logic [ofem_pkg::ENTRY_W-1:0] mem_q;
  logic                         vld_q;

  // storage write
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // valid flops, cleared at once
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
      vld_q <= vld[req.rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : ofem_pkg::EMPTY_CODE;

endmodule

`default_nettype wire

// File: design/oriented_facet_edge_map.sv
// ----------------------------------------------------------------------------
// oriented_facet_edge_map
// Directed edge to third corner map for building triangle meshes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command beat: clear map, add triangle, or read entry.
//   m_* returns one result beat per command: the map-valid flag after the
//   command and the entry read (-1 for empty or for non-read commands).
// Steps (one read and one write port on the map, one shared empty-compare):
//   clear, invalid op, add after failure: straight to the finishing state
//   read: one map read; add: three checked reads, then three writes,
//   or the checks alone when one of its edges is already taken
//   the next command is taken only when the sequencer is idle again, so
//   commands never overlap
// Reset: map reads empty everywhere and the failure flag is clear; the map
//   uses per-entry valid flops, so no clearing pass is needed.
// Stall: a result waits in the output register while m_tready is low; the
//   sequencer holds the next finished result until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module oriented_facet_edge_map (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [1:0] operation, [5:2] corner_a, [9:6] corner_b, [13:10] corner_c
  input  wire logic [15:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] map_valid, [5:1] read_value
  output logic [7:0]       m_tdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHK_AB = 3'd1;
  localparam logic [2:0] ST_CHK_BC = 3'd2;
  localparam logic [2:0] ST_CHK_CA = 3'd3;
  localparam logic [2:0] ST_WR_BC  = 3'd4;
  localparam logic [2:0] ST_WR_CA  = 3'd5;
  localparam logic [2:0] ST_RD     = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0]              state, state_next;
  ofem_pkg::node_t         ca, cb, cc;
  logic                    failed, failed_next;
  logic                    taken, taken_next;
  ofem_pkg::entry_t        res_value, res_value_next;
  ofem_pkg::store_req_t    req;
  ofem_pkg::entry_t        rd_data;
  logic                    entry_used;
  logic                    out_valid;
  logic                    out_map_valid;
  ofem_pkg::entry_t        out_value;
  logic                    accept;
  logic                    out_free;
  logic [1:0]              in_op;
  ofem_pkg::node_t         in_a, in_b, in_c;

  assign in_op = s_tdata[1:0];
  assign in_a  = s_tdata[5:2];
  assign in_b  = s_tdata[9:6];
  assign in_c  = s_tdata[13:10];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // shared compare: entry already owned
  assign entry_used = (rd_data != ofem_pkg::EMPTY_CODE);

  ofem_edge_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  // sequencer
  always_comb begin
    state_next     = state;
    failed_next    = failed;
    taken_next     = taken;
    res_value_next = res_value;
    req            = '0;
    req.wr_data    = ofem_pkg::ENTRY_W'(cc);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_value_next = ofem_pkg::EMPTY_CODE;
          req.rd_addr    = ofem_pkg::edge_addr(in_a, in_b);
          state_next     = ST_FIN;
          case (in_op)
            ofem_pkg::OP_CLEAR: begin
              req.clr     = 1'b1;
              failed_next = 1'b0;
            end
            ofem_pkg::OP_ADD: begin
              if (!failed) begin
                if (ofem_pkg::node_ok(in_a) && ofem_pkg::node_ok(in_b) &&
                    ofem_pkg::node_ok(in_c)) begin
                  req.rd_en  = 1'b1;
                  state_next = ST_CHK_AB;
                end else begin
                  failed_next = 1'b1;
                end
              end
            end
            ofem_pkg::OP_READ: begin
              if (ofem_pkg::node_ok(in_a) && ofem_pkg::node_ok(in_b)) begin
                req.rd_en  = 1'b1;
                state_next = ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHK_AB: begin
        taken_next  = entry_used;
        req.rd_en   = 1'b1;
        req.rd_addr = ofem_pkg::edge_addr(cb, cc);
        state_next  = ST_CHK_BC;
      end
      ST_CHK_BC: begin
        taken_next  = taken || entry_used;
        req.rd_en   = 1'b1;
        req.rd_addr = ofem_pkg::edge_addr(cc, ca);
        state_next  = ST_CHK_CA;
      end
      ST_CHK_CA: begin
        if (taken || entry_used) begin
          failed_next = 1'b1;
          state_next  = ST_FIN;
        end else begin
          req.wr_en   = 1'b1;
          req.wr_addr = ofem_pkg::edge_addr(ca, cb);
          req.wr_data = ofem_pkg::ENTRY_W'(cc);
          state_next  = ST_WR_BC;
        end
      end
      ST_WR_BC: begin
        req.wr_en   = 1'b1;
        req.wr_addr = ofem_pkg::edge_addr(cb, cc);
        req.wr_data = ofem_pkg::ENTRY_W'(ca);
        state_next  = ST_WR_CA;
      end
      ST_WR_CA: begin
        req.wr_en   = 1'b1;
        req.wr_addr = ofem_pkg::edge_addr(cc, ca);
        req.wr_data = ofem_pkg::ENTRY_W'(cb);
        state_next  = ST_FIN;
      end
      ST_RD: begin
        res_value_next = rd_data;
        state_next     = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      failed <= 1'b0;
    end else begin
      state  <= state_next;
      failed <= failed_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    taken     <= taken_next;
    res_value <= res_value_next;
    if (accept) begin
      ca <= in_a;
      cb <= in_b;
      cc <= in_c;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_map_valid <= !failed;
      out_value     <= res_value;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_value, out_map_valid};

endmodule

`default_nettype wire
